FILE: src/rrti_pkg.sv
// Package: shared types and constants of the ray radiative-transfer integrator.
package rrti_pkg;

    localparam int RAY_W   = 40;
    localparam int TOT_W   = 48;
    localparam int FIX_W   = 24;
    localparam int BIN_W   = 6;
    localparam int T_W     = 25;

    localparam logic [30:0]      EXP_M1_Q32 = 31'd1580030169;
    localparam logic [RAY_W-1:0] RAY_MAX    = {RAY_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX    = {TOT_W{1'b1}};
    localparam logic [3:0]       LAST_TERM  = 4'd13;

    localparam logic REG_SOURCE_MODE = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WAIT,
        S_MUL,
        S_SUM,
        S_WRITE
    } t_state;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_SETUP,
        TS_TMUL,
        TS_TDIV,
        TS_POW,
        TS_OUT
    } t_tstate;

    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

endpackage

FILE: src/rrti_if.sv
// Interfaces: segment request channel and result channel.
interface rrti_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  bin;
    logic [23:0] seg_len;
    logic [23:0] absorb;
    logic [23:0] emis;
    logic        ray_end;
    modport source (output valid, bin, seg_len, absorb, emis, ray_end, input ready);
    modport sink   (input valid, bin, seg_len, absorb, emis, ray_end, output ready);
endinterface

interface rrti_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  out_bin;
    logic [39:0] ray_value;
    logic [47:0] total_value;
    logic        zero_absorb;
    logic        total_saturated;
    modport source (output valid, out_bin, ray_value, total_value, zero_absorb,
                    total_saturated, input ready);
    modport sink   (input valid, out_bin, ray_value, total_value, zero_absorb,
                    total_saturated, output ready);
endinterface

FILE: src/rrti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrti_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [(D>1?$clog2(D):1)-1:0] i_waddr,
    input  logic [W-1:0]                 i_wdata,
    input  logic [(D>1?$clog2(D):1)-1:0] i_raddr,
    output logic [W-1:0]                 o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/rrti_div.sv
// Restoring divider, one quotient bit per cycle.
import rrti_pkg::*;
module rrti_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_sh   = {r_rem, r_quo[NW-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CW'(NW);
            end else if (r_cnt != '0) begin
                r_rem  <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_quo  <= {r_quo[NW-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CW'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: src/rrti_trans.sv
// Transmission unit: exp(-a*L) in Q1.24 by series and repeated exp(-1) products.
import rrti_pkg::*;
module rrti_trans (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_unit_ctl        i_ctl,
    input  logic [FIX_W-1:0] i_absorb,
    input  logic [FIX_W-1:0] i_seg_len,
    output t_unit_ctl        o_ctl,
    output logic [T_W-1:0]   o_trans
);
    t_tstate        r_state, n_state;
    logic [47:0]    r_x;
    logic [31:0]    r_f;
    logic [4:0]     r_n;
    logic [32:0]    r_term;
    logic [31:0]    r_tq;
    logic [33:0]    r_sum;
    logic [3:0]     r_k;
    logic [T_W-1:0] r_t;
    logic           r_done;
    logic [64:0]    w_tprod;
    logic [67:0]    w_qprod;
    logic [31:0]    w_quo;
    logic [64:0]    w_vprod;

    // ceil(2^36 / k): floor(q / k) = (q * m) >> 36 exactly for any 32-bit q
    function automatic logic [35:0] recip_k(logic [3:0] k);
        case (k)
            4'd2:    recip_k = 36'd34359738368;
            4'd3:    recip_k = 36'd22906492246;
            4'd4:    recip_k = 36'd17179869184;
            4'd5:    recip_k = 36'd13743895348;
            4'd6:    recip_k = 36'd11453246123;
            4'd7:    recip_k = 36'd9817068106;
            4'd8:    recip_k = 36'd8589934592;
            4'd9:    recip_k = 36'd7635497416;
            4'd10:   recip_k = 36'd6871947674;
            4'd11:   recip_k = 36'd6247225158;
            4'd12:   recip_k = 36'd5726623062;
            4'd13:   recip_k = 36'd5286113596;
            default: recip_k = 36'd0;
        endcase
    endfunction

    assign w_tprod = 65'(r_term) * 65'(r_f);
    assign w_qprod = 68'(r_tq) * 68'(recip_k(r_k));
    assign w_quo   = (r_k == 4'd1) ? r_tq : w_qprod[67:36];
    assign w_vprod = 65'(r_sum) * 65'(EXP_M1_Q32) + 65'h80000000;

    always_comb begin
        n_state = r_state;
        case (r_state)
            TS_IDLE:  if (i_ctl.start) n_state = TS_SETUP;
            TS_SETUP: n_state = (r_x[47:37] != '0) ? TS_OUT : TS_TMUL;
            TS_TMUL:  n_state = TS_TDIV;
            TS_TDIV:  n_state = (r_k == LAST_TERM) ? TS_POW : TS_TMUL;
            TS_POW:   if (r_n == '0) n_state = TS_OUT;
            TS_OUT:   n_state = TS_IDLE;
            default:  n_state = TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == TS_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            TS_IDLE: begin
                if (i_ctl.start) r_x <= 48'(i_absorb) * 48'(i_seg_len);
            end
            TS_SETUP: begin
                r_f    <= r_x[31:0];
                r_n    <= r_x[36:32];
                r_term <= 33'h100000000;
                r_k    <= 4'd1;
                // whole part of 32 or more: transmission is zero
                r_sum  <= (r_x[47:37] != '0) ? '0 : 34'h100000000;
            end
            TS_TMUL: begin
                r_tq <= w_tprod[63:32];
            end
            TS_TDIV: begin
                r_term <= {1'b0, w_quo};
                if (r_k[0]) begin
                    r_sum <= (34'(w_quo) > r_sum) ? '0 : r_sum - 34'(w_quo);
                end else begin
                    r_sum <= r_sum + 34'(w_quo);
                end
                r_k <= r_k + 1'b1;
            end
            TS_POW: begin
                if (r_n != '0) begin
                    r_sum <= 34'(w_vprod[64:32]);
                    r_n   <= r_n - 1'b1;
                end
            end
            TS_OUT: begin
                r_t <= T_W'((35'(r_sum) + 35'd128) >> 8);
            end
            default: ;
        endcase
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
    assign o_trans     = r_t;
endmodule

FILE: src/ray_radiative_transfer_integrator.sv
// Top level: ray intensity update and per-bin flux totals over two state RAMs.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------------
//  i_in    | in  | valid / ready    | bin, seg_len, absorb, emis, ray_end
//  o_out   | out | valid / ready    | out_bin, ray_value, total_value, zero_absorb,
//          |     |                  | total_saturated
//  apb     | in  | psel / penable   | paddr, pwdata, prdata (source_mode at 0x0)
//
// One request at a time; from acceptance to valid result the block runs 13 series
// terms, n exp(-1) products (n being the whole part of a*L, 0..31), four multiply
// steps, a sum and the write-back. n of 32 or more skips the series; in divide mode
// the source divide runs alongside. After reset the RAMs are cleared, one entry a
// cycle; no request is taken meanwhile. A new request is taken while a result waits
// on o_out.
import rrti_pkg::*;
module ray_radiative_transfer_integrator #(
    parameter int NUM_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrti_in_if.sink     i_in,
    rrti_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    t_state           r_state, n_state;
    logic             r_mode;
    logic [AW-1:0]    r_clr;

    // latched request
    logic [BIN_W-1:0] r_bin;
    logic [FIX_W-1:0] r_len, r_abs, r_emis;
    logic             r_end, r_valid, r_zflag;
    logic [AW-1:0]    r_addr;

    logic             r_tdone, r_ddone;
    logic [RAY_W-1:0] r_cur, r_s;
    logic [T_W-1:0]   r_t, r_omt;
    logic [1:0]       r_step;
    logic [64:0]      r_acc1, r_acc2;
    logic [RAY_W-1:0] r_ray;

    // result register
    logic             r_ovalid;
    logic [BIN_W-1:0] r_obin;
    logic [RAY_W-1:0] r_oray;
    logic [TOT_W-1:0] r_otot;
    logic             r_oz, r_osat;

    t_unit_ctl        w_tctl_in, w_tctl_out;
    logic [T_W-1:0]   w_trans;
    logic             w_dstart, w_ddone;
    logic [47:0]      w_quo;
    logic [RAY_W-1:0] w_ray_rd;
    logic [TOT_W-1:0] w_tot_rd;
    logic             w_ray_we, w_tot_we;
    logic [AW-1:0]    w_waddr;
    logic [RAY_W-1:0] w_ray_wd;
    logic [TOT_W-1:0] w_tot_wd;
    logic             w_accept, w_ofree;
    logic [19:0]      w_ma;
    logic [T_W-1:0]   w_mb;
    logic [44:0]      w_prod;
    logic [65:0]      w_pp;
    logic [41:0]      w_rsum;
    logic [TOT_W:0]   w_tsum;
    logic             w_tsat;
    logic [TOT_W-1:0] w_tnew;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SOURCE_MODE) ? {31'b0, r_mode} : '0;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_ofree  = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    rrti_ram #(.W(RAY_W), .D(NUM_BINS)) u_ray_ram (
        .i_clk   (i_clk),
        .i_we    (w_ray_we),
        .i_waddr (w_waddr),
        .i_wdata (w_ray_wd),
        .i_raddr (r_addr),
        .o_rdata (w_ray_rd)
    );

    rrti_ram #(.W(TOT_W), .D(NUM_BINS)) u_tot_ram (
        .i_clk   (i_clk),
        .i_we    (w_tot_we),
        .i_waddr (w_waddr),
        .i_wdata (w_tot_wd),
        .i_raddr (r_addr),
        .o_rdata (w_tot_rd)
    );

    assign w_tctl_in.start = (r_state == S_START);
    assign w_tctl_in.done  = 1'b0;

    rrti_trans u_trans (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tctl_in),
        .i_absorb  (r_abs),
        .i_seg_len (r_len),
        .o_ctl     (w_tctl_out),
        .o_trans   (w_trans)
    );

    // source divide only in divide mode with nonzero absorptivity
    assign w_dstart = (r_state == S_START) && r_mode && (r_abs != '0);

    rrti_div #(.NW(48), .DW(FIX_W)) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   ({r_emis, 24'b0}),
        .i_den   (r_abs),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    // one 20x25 multiplier over four steps: two halves of I*T, two of S*(1-T)
    always_comb begin
        case (r_step)
            2'd0:    begin w_ma = r_cur[19:0];  w_mb = r_t;   end
            2'd1:    begin w_ma = r_cur[39:20]; w_mb = r_t;   end
            2'd2:    begin w_ma = r_s[19:0];    w_mb = r_omt; end
            default: begin w_ma = r_s[39:20];   w_mb = r_omt; end
        endcase
    end
    assign w_prod = 45'(w_ma) * 45'(w_mb);
    assign w_pp   = r_step[0] ? (66'(w_prod) << 20) : 66'(w_prod);

    assign w_rsum = 42'((r_acc1 + 65'h800000) >> 24) + 42'((r_acc2 + 65'h800000) >> 24);

    assign w_tsum = {1'b0, w_tot_rd} + (TOT_W+1)'(r_ray);
    assign w_tsat = w_tsum[TOT_W];
    assign w_tnew = w_tsat ? TOT_MAX : w_tsum[TOT_W-1:0];

    always_comb begin
        n_state  = r_state;
        w_ray_we = 1'b0;
        w_tot_we = 1'b0;
        w_waddr  = r_addr;
        w_ray_wd = r_ray;
        w_tot_wd = w_tnew;
        case (r_state)
            S_CLEAR: begin
                w_ray_we = 1'b1;
                w_tot_we = 1'b1;
                w_waddr  = r_clr;
                w_ray_wd = '0;
                w_tot_wd = '0;
                if (r_clr == AW'(NUM_BINS - 1)) n_state = S_IDLE;
            end
            S_IDLE:  if (w_accept) n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (r_tdone && r_ddone) n_state = S_MUL;
            S_MUL:   if (r_step == 2'd3) n_state = S_SUM;
            S_SUM:   n_state = S_WRITE;
            S_WRITE: begin
                if (w_ofree) begin
                    n_state  = S_IDLE;
                    w_ray_we = r_valid;
                    w_tot_we = r_valid && r_end;
                    // last segment: fold into the total and clear the ray
                    w_ray_wd = r_end ? '0 : r_ray;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_mode   <= 1'b0;
            r_ovalid <= 1'b0;
            r_tdone  <= 1'b0;
            r_ddone  <= 1'b0;
            r_step   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (psel && penable && pwrite && paddr[2] == REG_SOURCE_MODE) begin
                r_mode <= pwdata[0];
            end
            if (o_out.ready) r_ovalid <= 1'b0;
            if (r_state == S_WRITE && w_ofree) r_ovalid <= 1'b1;
            if (r_state == S_START) begin
                r_tdone <= 1'b0;
                r_ddone <= !(r_mode && (r_abs != '0));
            end else begin
                if (w_tctl_out.done) r_tdone <= 1'b1;
                if (w_ddone) r_ddone <= 1'b1;
            end
            if (r_state == S_MUL) r_step <= r_step + 1'b1;
            else r_step <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin   <= i_in.bin;
            r_len   <= i_in.seg_len;
            r_abs   <= i_in.absorb;
            r_emis  <= i_in.emis;
            r_end   <= i_in.ray_end;
            r_valid <= (32'(i_in.bin) < 32'(NUM_BINS));
            r_addr  <= AW'(i_in.bin);
        end
        if (r_state == S_WAIT && r_tdone && r_ddone) begin
            r_t     <= w_trans;
            r_omt   <= T_W'(25'h1000000 - w_trans);
            r_cur   <= r_valid ? w_ray_rd : '0;
            r_zflag <= r_mode && (r_abs == '0);
            if (!r_mode) begin
                r_s <= {8'b0, r_emis, 8'b0};
            end else if (r_abs == '0) begin
                r_s <= '0;
            end else begin
                r_s <= (w_quo[47:RAY_W] != '0) ? RAY_MAX : w_quo[RAY_W-1:0];
            end
            r_acc1 <= '0;
            r_acc2 <= '0;
        end
        if (r_state == S_MUL) begin
            if (r_step[1]) r_acc2 <= r_acc2 + w_pp[64:0];
            else           r_acc1 <= r_acc1 + w_pp[64:0];
        end
        if (r_state == S_SUM) begin
            r_ray <= (w_rsum[41:RAY_W] != '0) ? RAY_MAX : w_rsum[RAY_W-1:0];
        end
        if (r_state == S_WRITE && w_ofree) begin
            r_obin <= r_bin;
            r_oray <= r_ray;
            r_oz   <= r_zflag;
            if (!r_valid) begin
                r_otot <= '0;
                r_osat <= 1'b0;
            end else if (r_end) begin
                r_otot <= w_tnew;
                r_osat <= w_tsat;
            end else begin
                r_otot <= w_tot_rd;
                r_osat <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.out_bin         = r_obin;
    assign o_out.ray_value       = r_oray;
    assign o_out.total_value     = r_otot;
    assign o_out.zero_absorb     = r_oz;
    assign o_out.total_saturated = r_osat;
endmodule

FILE: test/tb_rrti_checker.sv
// Checker: flux integration predictor and result comparison for the integrator.
`timescale 1ns / 100ps
import rrti_pkg::*;
module tb_rrti_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rrti_in_if   seg_ch,
    rrti_out_if  res_ch,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    input  logic pready,
    output int   o_pending,
    output int   o_errors
);

    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [RAY_W-1:0] ray;
        logic [TOT_W-1:0] total;
        logic             zero_absorb;
        logic             saturated;
    } t_flux_result;

    t_flux_result    flux_expected[$];
    logic [RAY_W-1:0] ray_store [64];
    logic [TOT_W-1:0] total_store [64];
    logic             divide_mode;
    int               errors;
    int               pending;

    assign o_pending = pending;
    assign o_errors  = errors;

    // exp(-a*L) in Q1.24
    function automatic logic [63:0] transmission_q24(logic [23:0] a, logic [23:0] len);
        logic [63:0] x, n, f, sum, term, v;
        x = 64'(a) * 64'(len);
        n = x >> 32;
        if (n >= 32) return 64'd0;
        f = {32'd0, x[31:0]};
        sum = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 13; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k % 2 == 1) sum = (term > sum) ? 64'd0 : sum - term;
            else sum = sum + term;
        end
        v = sum;
        for (int i = 0; i < n; i++) v = (v * 64'(EXP_M1_Q32) + (64'd1 << 31)) >> 32;
        return (v + 64'd128) >> 8;
    endfunction

    function automatic t_flux_result integrate_segment(logic [5:0] bin, logic [23:0] len,
                                                       logic [23:0] a, logic [23:0] e,
                                                       logic last);
        t_flux_result r;
        logic [63:0] t, s, ray, sum;
        t = transmission_q24(a, len);
        r.zero_absorb = 1'b0;
        r.saturated = 1'b0;
        if (divide_mode) begin
            if (a == 0) begin
                s = 64'd0;
                r.zero_absorb = 1'b1;
            end else begin
                s = (64'(e) << 24) / 64'(a);
                if (s > 64'(RAY_MAX)) s = 64'(RAY_MAX);
            end
        end else begin
            s = 64'(e) << 8;
        end
        ray = ((64'(ray_store[bin]) * t + (64'd1 << 23)) >> 24)
            + ((s * ((64'd1 << 24) - t) + (64'd1 << 23)) >> 24);
        if (ray > 64'(RAY_MAX)) ray = 64'(RAY_MAX);
        r.bin = bin;
        r.ray = ray[RAY_W-1:0];
        r.total = total_store[bin];
        if (last) begin
            sum = 64'(total_store[bin]) + ray;
            if (sum > 64'(TOT_MAX)) begin
                sum = 64'(TOT_MAX);
                r.saturated = 1'b1;
            end
            r.total = sum[TOT_W-1:0];
            total_store[bin] = r.total;
            ray_store[bin] = '0;
        end else begin
            ray_store[bin] = r.ray;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_flux_result w;
        if (!i_rst_n) begin
            flux_expected.delete();
            for (int i = 0; i < 64; i++) begin
                ray_store[i] = '0;
                total_store[i] = '0;
            end
            divide_mode = 1'b0;
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_SOURCE_MODE)
                divide_mode = pwdata[0];
            if (seg_ch.valid && seg_ch.ready)
                flux_expected.insert(flux_expected.size(),
                    integrate_segment(seg_ch.bin, seg_ch.seg_len,
                    seg_ch.absorb, seg_ch.emis, seg_ch.ray_end));
            if (res_ch.valid && res_ch.ready) begin
                if (flux_expected.size() == 0) begin
                    report_mismatch("unexpected result", res_ch.out_bin, 0);
                end else begin
                    w = flux_expected.pop_front();
                    if (res_ch.out_bin != w.bin)
                        report_mismatch("out_bin", res_ch.out_bin, w.bin);
                    if (res_ch.ray_value != w.ray)
                        report_mismatch("ray_value", res_ch.ray_value, w.ray);
                    if (res_ch.total_value != w.total)
                        report_mismatch("total_value", res_ch.total_value, w.total);
                    if (res_ch.zero_absorb != w.zero_absorb)
                        report_mismatch("zero_absorb", res_ch.zero_absorb, w.zero_absorb);
                    if (res_ch.total_saturated != w.saturated)
                        report_mismatch("total_saturated", res_ch.total_saturated,
                                        w.saturated);
                end
            end
        end
        pending = flux_expected.size();
    end

endmodule

FILE: test/tb_ray_radiative_transfer_integrator.sv
// Testbench top: segment stimulus, configuration writes and the verdict.
`timescale 1ns / 100ps
import rrti_pkg::*;
module tb_ray_radiative_transfer_integrator;

    localparam int DRAIN_CYCLES = 600;    // well above the longest request latency
    localparam int STALL_LIMIT  = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          pending, errors, quiet_cycles;
    int          send_idle_pct, recv_stall_pct;

    rrti_in_if  seg_if ();
    rrti_out_if res_if ();

    ray_radiative_transfer_integrator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(seg_if.sink), .o_out(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_rrti_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .seg_ch(seg_if), .res_ch(res_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_pending(pending), .o_errors(errors)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Stall the result side at random, per the current phase.
    always @(posedge i_clk)
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL ray_radiative_transfer_integrator");
            $finish;
        end
    end

    // Random Q8.16 value with a random number of significant bits, so that
    // a*L spreads over the whole transmission range.
    function automatic logic [23:0] rand_fix();
        logic [23:0] m;
        m = 24'((32'd1 << $urandom_range(24)) - 1);
        return 24'($urandom) & m;
    endfunction

    // Drive one request; hold valid until it is taken.
    task automatic send_segment(logic [5:0] bin, logic [23:0] len, logic [23:0] a,
                                logic [23:0] e, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            seg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_if.valid   <= 1'b1;
        seg_if.bin     <= bin;
        seg_if.seg_len <= len;
        seg_if.absorb  <= a;
        seg_if.emis    <= e;
        seg_if.ray_end <= last;
        do @(posedge i_clk); while (!seg_if.ready);
    endtask

    // Drop valid, wait until every result is back, then let the block settle.
    task automatic drain();
        seg_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(logic mode);
        apb_write(3'd0, {31'($urandom), mode});
    endtask

    initial begin
        logic [5:0] bin;
        i_rst_n = 1'b0;
        seg_if.valid = 1'b0;
        seg_if.bin = '0;
        seg_if.seg_len = '0;
        seg_if.absorb = '0;
        seg_if.emis = '0;
        seg_if.ray_end = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, emissivity as source: extremes, zero absorptivity keeps
        // the intensity, transmission around the n = 32 cutoff.
        send_segment(6'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        send_segment(6'd63, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_segment(6'd1, 24'h010000, 24'h008000, 24'hFFFFFF, 1'b0);
        send_segment(6'd1, 24'h123456, 24'd0, 24'h00ABCD, 1'b0);
        send_segment(6'd1, 24'h020000, 24'h010000, 24'h001000, 1'b1);
        send_segment(6'd2, 24'hFFFFFF, 24'd7937, 24'hFFFFFF, 1'b0);
        send_segment(6'd2, 24'hFFFFFF, 24'd8192, 24'h800000, 1'b0);
        send_segment(6'd2, 24'hFFFFFF, 24'd8193, 24'h000001, 1'b1);
        send_segment(6'd42, 24'h000001, 24'h000001, 24'h555555, 1'b1);
        send_segment(6'd21, 24'hAAAAAA, 24'h000100, 24'hAAAAAA, 1'b1);
        send_segment(6'd63, 24'h000100, 24'h000100, 24'hFFFFFF, 1'b1);
        drain();

        // Directed, divide mode: zero absorptivity flag, source saturation.
        set_mode(1'b1);
        send_segment(6'd3, 24'h010000, 24'd0, 24'hFFFFFF, 1'b0);
        send_segment(6'd3, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 1'b0);
        send_segment(6'd3, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 1'b1);
        send_segment(6'd4, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_segment(6'd4, 24'h000000, 24'h000000, 24'h000000, 1'b1);
        send_segment(6'd5, 24'h008000, 24'h010000, 24'd0, 1'b1);
        send_segment(6'd5, 24'hFFFFFF, 24'h000100, 24'hFFFFFF, 1'b1);
        drain();
        // Unknown register index must be ignored.
        apb_write(3'd4, 32'hFFFF_FFFE);

        // Random phases: each phase has its own idle mix; odd phases run in divide mode.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 36 : 46) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 36 : 46) : 0;
            set_mode(ph[0]);
            if (ph == 1) begin
                // Hammer one bin with large rays so its total clips at the top.
                for (int n = 0; n < 430; n++)
                    send_segment(6'd63, 24'hFFFFFF, 24'h000100, 24'hFFFFFF, 1'b1);
            end
            for (int n = 0; n < 300; n++) begin
                // Mostly rays on a few bins so intensities chain; some noise.
                bin = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(7));
                case ($urandom_range(9))
                    0: send_segment(bin, 24'($urandom), 24'($urandom), 24'($urandom),
                                    1'($urandom));
                    1: send_segment(bin, rand_fix(), 24'd0, rand_fix(), 1'($urandom));
                    default: send_segment(bin, rand_fix(), rand_fix(), rand_fix(),
                                          $urandom_range(3) == 0);
                endcase
            end
            drain();
        end

        if (errors == 0)
            $display("PASS ray_radiative_transfer_integrator");
        else
            $display("FAIL ray_radiative_transfer_integrator");
        $finish;
    end

endmodule
